FILE: rtl/vrp_pkg.sv
// Shared types, constants and descriptor builder for the VP8 RTP packetizer.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

    localparam int LENGTH_BITS_DEF = 12;
    localparam int CAP_W           = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 15;
    localparam int DESC_MAX        = 6;
    localparam int DLEN_W          = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 12'd1200;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_FLAGS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICTURE_ID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TL0_INDEX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPORAL_ID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_INDEX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 3'd5;

    localparam logic [14:0] PID_HIGH_MASK = 15'h7F00;
    localparam logic [14:0] PID_LOW_MASK  = 15'h00FF;

    typedef struct packed {
        logic [5:0]       flags;
        logic [14:0]      pid;
        logic [7:0]       tl0;
        logic [1:0]       tid;
        logic [4:0]       kidx;
        logic [CAP_W-1:0] cap;
    } t_cfg;

    typedef struct packed {
        logic [DESC_MAX-1:0][7:0] bytes;
        logic [DLEN_W-1:0]        len;
    } t_desc;

    // One queued item: descriptor bytes still to send (len 0 = none), then the data byte.
    typedef struct packed {
        logic [DESC_MAX-1:0][7:0] desc;
        logic [DLEN_W-1:0]        dlen;
        logic [7:0]               data;
        logic                     eop;
        logic                     eof;
        logic                     err;
    } t_entry;

    function automatic t_desc build_desc(input t_cfg c);
        t_desc             d;
        logic [DLEN_W-1:0] n;
        logic [14:0]       hi;
        logic [14:0]       lo;
        d  = '0;
        n  = 3'd1;
        hi = (c.pid & PID_HIGH_MASK) >> 8;
        lo = c.pid & PID_LOW_MASK;
        d.bytes[0] = c.flags[0] ? 8'h20 : 8'h00;
        if (|c.flags[4:1]) begin
            d.bytes[0][7] = 1'b1;
            n = 3'd2;
            if (c.flags[1]) begin
                d.bytes[1][7] = 1'b1;
                if (c.pid >= 15'd128) begin
                    d.bytes[n]        = {1'b1, hi[6:0]};
                    d.bytes[n + 3'd1] = lo[7:0];
                    n = n + 3'd2;
                end else begin
                    d.bytes[n] = {1'b0, c.pid[6:0]};
                    n = n + 3'd1;
                end
            end
            if (c.flags[2]) begin
                d.bytes[1][6] = 1'b1;
                d.bytes[n] = c.tl0;
                n = n + 3'd1;
            end
            if (c.flags[3] || c.flags[4]) begin
                d.bytes[1][5] = c.flags[3];
                d.bytes[1][4] = c.flags[4];
                d.bytes[n] = {(c.flags[3] ? c.tid : 2'b00), c.flags[5],
                              (c.flags[4] ? c.kidx : 5'd0)};
                n = n + 3'd1;
            end
        end
        d.len = n;
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vrp_front.sv
// Front end: packet bookkeeping and classification of each accepted byte.
`timescale 1ns / 1ps
`default_nettype none

module vrp_front
    import vrp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic   i_last_of_frame,
    input  wire t_cfg   i_cfg,
    output t_entry      o_entry
);

    localparam int SUM_W = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 1;
    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_frame_start, n_frame_start;

    t_desc                  desc;
    logic                   opening;
    logic                   drop;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [SUM_W-1:0]       fill;
    logic                   eop;

    always_comb begin
        desc      = build_desc(i_cfg);
        opening   = (r_count == '0);
        drop      = opening && ({{(SUM_W-CAP_W){1'b0}}, i_cfg.cap} <=
                                {{(SUM_W-DLEN_W){1'b0}}, desc.len});
        count_inc = r_count + 1'b1;
        fill      = {{(SUM_W-DLEN_W){1'b0}}, desc.len} +
                    {{(SUM_W-LENGTH_BITS){1'b0}}, count_inc};
        eop       = i_last_of_frame ||
                    (fill >= {{(SUM_W-CAP_W){1'b0}}, i_cfg.cap}) ||
                    (count_inc == CNT_MAX);

        o_entry = '0;
        if (drop) begin
            o_entry.eof = i_last_of_frame;
            o_entry.err = 1'b1;
        end else begin
            o_entry.data = i_data_byte;
            o_entry.eop  = eop;
            o_entry.eof  = i_last_of_frame;
            if (opening) begin
                o_entry.desc       = desc.bytes;
                o_entry.desc[0][4] = r_frame_start;
                o_entry.dlen       = desc.len;
            end
        end

        n_count       = r_count;
        n_frame_start = r_frame_start;
        if (i_accept) begin
            if (!drop) begin
                n_count = eop ? '0 : count_inc;
                if (opening) begin
                    n_frame_start = 1'b0;
                end
            end
            if (i_last_of_frame) begin
                n_frame_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_frame_start <= 1'b1;
        end else begin
            r_count       <= n_count;
            r_frame_start <= n_frame_start;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vrp_queue.sv
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module vrp_queue
    import vrp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_head
);

    t_entry     r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        o_full  = (r_cnt == 2'd2);
        o_valid = (r_cnt != 2'd0);
        o_head  = r_mem[r_rp];
        n_wp    = r_wp ^ i_push;
        n_rp    = r_rp ^ i_pop;
        n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vrp_back.sv
// Back end: serializes descriptor bytes and the data byte into the output register.
`timescale 1ns / 1ps
`default_nettype none

module vrp_back
    import vrp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_packet,
    output logic        o_end_of_frame,
    output logic        o_capacity_error
);

    logic [DLEN_W-1:0] r_idx, n_idx;
    logic              r_ov, n_ov;
    logic [7:0]        r_byte;
    logic              r_eop, r_eof, r_err;

    logic              load;
    logic              fire;
    logic              is_data;
    logic [7:0]        sel_byte;

    always_comb begin
        load     = !r_ov || i_out_ready;
        fire     = load && i_head_valid;
        is_data  = (r_idx == i_head.dlen);
        sel_byte = is_data ? i_head.data : i_head.desc[r_idx];
        o_pop    = fire && is_data;
        n_idx    = r_idx;
        if (fire) begin
            n_idx = is_data ? '0 : r_idx + 1'b1;
        end
        n_ov = load ? i_head_valid : r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= sel_byte;
            r_eop  <= is_data && i_head.eop;
            r_eof  <= is_data && i_head.eof;
            r_err  <= is_data && i_head.err;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out_byte       = r_byte;
    assign o_end_of_packet  = r_eop;
    assign o_end_of_frame   = r_eof;
    assign o_capacity_error = r_err;

endmodule

`default_nettype wire

FILE: rtl/vp8_rtp_packetizer.sv
// Top level of the VP8 RTP packetizer: registers, front end, queue, back end.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_data_byte, i_last_of_frame
//  out      | output    | o_out_valid / i_out_ready  | o_out_byte, o_end_of_packet,
//           |           |                            | o_end_of_frame, o_capacity_error
//  cfg      | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// An item inside a packet gives one output item per cycle unless the output stalls;
// an item that opens a packet gives its descriptor bytes and data byte, 2 to 7 in all.
// The front end classifies in the accept cycle; a two-entry queue decouples it from the
// back end, so input is taken while output stalls until the queue fills.
// Synchronous active-low reset clears control state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module vp8_rtp_packetizer
    import vrp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_of_frame,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_end_of_packet,
    output logic                       o_end_of_frame,
    output logic                       o_capacity_error,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg, n_cfg;
    t_entry entry;
    t_entry head;
    logic   accept;
    logic   q_full;
    logic   q_valid;
    logic   pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_FLAGS: n_cfg.flags = i_cfg_data[5:0];
                REG_PICTURE_ID:  n_cfg.pid   = i_cfg_data[14:0];
                REG_TL0_INDEX:   n_cfg.tl0   = i_cfg_data[7:0];
                REG_TEMPORAL_ID: n_cfg.tid   = i_cfg_data[1:0];
                REG_KEY_INDEX:   n_cfg.kidx  = i_cfg_data[4:0];
                REG_CAPACITY:    n_cfg.cap   = i_cfg_data[CAP_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{flags: '0, pid: '0, tl0: '0, tid: '0, kidx: '0, cap: CAP_RESET};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    vrp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_last_of_frame (i_last_of_frame),
        .i_cfg           (r_cfg),
        .o_entry         (entry)
    );

    vrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    vrp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (q_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_end_of_packet  (o_end_of_packet),
        .o_end_of_frame   (o_end_of_frame),
        .o_capacity_error (o_capacity_error)
    );

`ifndef ASSERT_OFF
    // A dropped byte never closes a packet.
    a_err_no_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_capacity_error |-> !o_end_of_packet)
        else $error("capacity error flagged on a packet end");

    // Frame end comes only on a packet end or a dropped byte.
    a_eof_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_end_of_packet || o_capacity_error)
        else $error("frame end without packet end");

    // Output is empty and input open right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input stalled after reset");
`endif

endmodule

`default_nettype wire
